// ===== design/qmtb_pkg.sv =====
// Shared constants, field codes and lane interface types for the timer bank.
package qmtb_pkg;

   localparam int NUM_TIMERS = 4;
   localparam int NUM_MATCH  = 4;

   localparam int DATA_W      = 32;
   localparam int FUNC_W      = 2;
   localparam int TIMER_SEL_W = 2;
   localparam int REG_SEL_W   = 3;
   localparam int CTRL_W      = 2;
   localparam int MCR_W       = 12;
   localparam int MCR_BITS    = 3;
   localparam int IRQ_W       = 16;
   localparam int RUN_W       = 4;
   localparam int IRQ_STRIDE  = 4;
   localparam int MATCH_IDX_W = (NUM_MATCH > 1) ? $clog2(NUM_MATCH) : 1;

   localparam int REQ_TUSER_W = FUNC_W + TIMER_SEL_W + REG_SEL_W;
   localparam int REQ_TDATA_W = DATA_W;
   localparam int RSP_BITS    = DATA_W + IRQ_W + RUN_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [REG_SEL_W-1:0] REG_CTRL      = 3'd0;
   localparam logic [REG_SEL_W-1:0] REG_COUNT     = 3'd1;
   localparam logic [REG_SEL_W-1:0] REG_MCR       = 3'd2;
   localparam logic [REG_SEL_W-1:0] REG_MATCH0    = 3'd3;
   localparam logic [REG_SEL_W-1:0] REG_MATCH_END = REG_SEL_W'(3 + NUM_MATCH);

   localparam int CTRL_ENABLE = 0;
   localparam int CTRL_HOLD   = 1;

   localparam int MCR_IRQ  = 0;
   localparam int MCR_RST  = 1;
   localparam int MCR_STOP = 2;

   typedef struct packed {
      logic                 tick;
      logic                 wr;
      logic                 rd;
      logic [REG_SEL_W-1:0] reg_sel;
      logic [DATA_W-1:0]    wdata;
   } lane_req_type;

   typedef struct packed {
      logic [NUM_MATCH-1:0] irq;
      logic                 running;
      logic [DATA_W-1:0]    rdata;
   } lane_rsp_type;

endpackage

// ===== design/qmtb_lane.sv =====
// One timer: control, counter, match registers, match control and tick logic.
module qmtb_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  sel,
   input  qmtb_pkg::lane_req_type req,
   output qmtb_pkg::lane_rsp_type rsp
);
   import qmtb_pkg::*;

   logic [CTRL_W-1:0]      ctrl_ff, ctrl_in;
   logic [DATA_W-1:0]      count_ff, count_in;
   logic [MCR_W-1:0]       mcr_ff, mcr_in;
   logic [DATA_W-1:0]      match_ff [NUM_MATCH];
   logic [DATA_W-1:0]      match_in [NUM_MATCH];
   logic [DATA_W-1:0]      cnt_inc;
   logic [NUM_MATCH-1:0]   hit;
   logic [NUM_MATCH-1:0]   irq_hit;
   logic                   clr_hit;
   logic                   stop_hit;
   logic                   counting;
   logic                   is_match;
   logic [MATCH_IDX_W-1:0] match_idx;
   logic                   wr_en;
   logic                   rd_en;

   assign cnt_inc   = count_ff + DATA_W'(1);
   assign counting  = ctrl_ff[CTRL_ENABLE] && !ctrl_ff[CTRL_HOLD];
   assign is_match  = (req.reg_sel >= REG_MATCH0) && (req.reg_sel < REG_MATCH_END);
   assign match_idx = MATCH_IDX_W'(req.reg_sel - REG_MATCH0);
   assign wr_en     = req.wr && sel;
   assign rd_en     = req.rd && sel;

   always_comb begin
      clr_hit  = 1'b0;
      stop_hit = 1'b0;
      for (int n = 0; n < NUM_MATCH; n++) begin
         hit[n]     = (cnt_inc == match_ff[n]);
         irq_hit[n] = hit[n] && mcr_ff[MCR_BITS*n + MCR_IRQ];
         clr_hit    = clr_hit  | (hit[n] && mcr_ff[MCR_BITS*n + MCR_RST]);
         stop_hit   = stop_hit | (hit[n] && mcr_ff[MCR_BITS*n + MCR_STOP]);
      end
   end

   always_comb begin
      ctrl_in  = ctrl_ff;
      count_in = count_ff;
      mcr_in   = mcr_ff;
      match_in = match_ff;
      if (req.tick) begin
         if (ctrl_ff[CTRL_HOLD]) begin
            count_in = '0;
         end else if (ctrl_ff[CTRL_ENABLE]) begin
            count_in = clr_hit ? '0 : cnt_inc;
            if (stop_hit) begin
               ctrl_in[CTRL_ENABLE] = 1'b0;
            end
         end
      end else if (wr_en) begin
         if (req.reg_sel == REG_CTRL) begin
            ctrl_in = req.wdata[CTRL_W-1:0];
         end else if (req.reg_sel == REG_COUNT) begin
            count_in = req.wdata;
         end else if (req.reg_sel == REG_MCR) begin
            mcr_in = req.wdata[MCR_W-1:0];
         end else if (is_match) begin
            match_in[match_idx] = req.wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff  <= '0;
         count_ff <= '0;
         mcr_ff   <= '0;
         for (int n = 0; n < NUM_MATCH; n++) begin
            match_ff[n] <= '0;
         end
      end else begin
         ctrl_ff  <= ctrl_in;
         count_ff <= count_in;
         mcr_ff   <= mcr_in;
         match_ff <= match_in;
      end
   end

   always_comb begin
      rsp.irq     = (req.tick && counting) ? irq_hit : '0;
      rsp.running = ctrl_in[CTRL_ENABLE];
      rsp.rdata   = '0;
      if (rd_en) begin
         if (req.reg_sel == REG_CTRL) begin
            rsp.rdata = DATA_W'(ctrl_ff);
         end else if (req.reg_sel == REG_COUNT) begin
            rsp.rdata = count_ff;
         end else if (req.reg_sel == REG_MCR) begin
            rsp.rdata = DATA_W'(mcr_ff);
         end else if (is_match) begin
            rsp.rdata = match_ff[match_idx];
         end
      end
   end

endmodule

// ===== design/qmtb_merge.sv =====
// Merge of the lane results and the two-entry output stage (register plus skid).
module qmtb_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             fire,
   input  qmtb_pkg::lane_rsp_type           lane_rsp [qmtb_pkg::NUM_TIMERS],
   output logic                             req_tready,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [qmtb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import qmtb_pkg::*;

   logic [DATA_W-1:0]      rdata;
   logic [IRQ_W-1:0]       irq_flags;
   logic [RUN_W-1:0]       running;
   logic [RSP_TDATA_W-1:0] result;

   logic                   out_valid_ff, out_valid_in;
   logic [RSP_TDATA_W-1:0] out_data_ff, out_data_in;
   logic                   skid_valid_ff, skid_valid_in;
   logic [RSP_TDATA_W-1:0] skid_data_ff, skid_data_in;
   logic                   take;

   always_comb begin
      rdata     = '0;
      irq_flags = '0;
      running   = '0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         rdata = rdata | lane_rsp[t].rdata;
         if (t < RUN_W) begin
            running[t] = lane_rsp[t].running;
         end
         for (int n = 0; n < NUM_MATCH; n++) begin
            if (IRQ_STRIDE*t + n < IRQ_W) begin
               irq_flags[IRQ_STRIDE*t + n] = lane_rsp[t].irq[n];
            end
         end
      end
      result = RSP_TDATA_W'({running, irq_flags, rdata});
   end

   assign take       = out_valid_ff && rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (fire) begin
         if (!out_valid_ff || take) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (take) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

// ===== design/quad_match_timer_bank_core.sv =====
// Top level of the four-timer match bank: lanes, result merge and stream ports.
//
//   channel | dir | ports        | transfer carries
//   --------+-----+--------------+--------------------------------------------
//   req     | in  | req_t*       | tick, register write or register read
//   rsp     | out | rsp_t*       | read data, match interrupt flags, run bits
//
// Every transfer on req is handled in the cycle it is accepted; one item per cycle
// while req_tready is high. Each result is registered, in the skid stage if rsp is stalled.
// Output register plus skid stage: req_tready drops only when two results wait.
// Synchronous reset clears all counters, match and control registers.
module quad_match_timer_bank_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [qmtb_pkg::REQ_TDATA_W-1:0] req_tdata,   // wdata[31:0]
   input  logic [qmtb_pkg::REQ_TUSER_W-1:0] req_tuser,   // func[1:0], timer_sel[3:2], reg_sel[6:4]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [qmtb_pkg::RSP_TDATA_W-1:0] rsp_tdata    // rdata[31:0], irq_flags[47:32],
                                                         // running[51:48], zero[55:52]
);
   import qmtb_pkg::*;

   logic                   fire;
   logic [FUNC_W-1:0]      func;
   logic [TIMER_SEL_W-1:0] timer_sel;
   lane_req_type           lane_req;
   lane_rsp_type           lane_rsp [NUM_TIMERS];

   assign fire      = req_tvalid && req_tready;
   assign func      = req_tuser[FUNC_W-1:0];
   assign timer_sel = req_tuser[FUNC_W +: TIMER_SEL_W];

   always_comb begin
      lane_req.tick    = fire && (func == FUNC_TICK);
      lane_req.wr      = fire && (func == FUNC_WRITE);
      lane_req.rd      = fire && (func == FUNC_READ);
      lane_req.reg_sel = req_tuser[FUNC_W + TIMER_SEL_W +: REG_SEL_W];
      lane_req.wdata   = req_tdata;
   end

   for (genvar t = 0; t < NUM_TIMERS; t++) begin : g_lane
      qmtb_lane u_lane (
         .clock (clock),
         .reset (reset),
         .sel   (int'(timer_sel) == t),
         .req   (lane_req),
         .rsp   (lane_rsp[t])
      );
   end

   qmtb_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .lane_rsp   (lane_rsp),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/qmtb_checker.sv =====
// Port-level checks of the timer bank and their binding to the top level.
module qmtb_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [qmtb_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import qmtb_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result shown right after reset");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_irq_or_read: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[DATA_W-1:0] == '0)
                  || (rsp_tdata[DATA_W +: IRQ_W] == '0))
      else $error("read data and match flags in one result");

endmodule

bind quad_match_timer_bank_core qmtb_checker u_qmtb_checker (.*);
